### design/dsf_pkg.sv
`timescale 1ns / 1ps
// Shared constants, widths and side-band structs for the damped spring force block.
package dsf_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int WORD_W = 32;            // field and register width
  localparam int ADDR_W = 4;             // three registers at 0x0, 0x4, 0x8
  localparam int DW     = WORD_W + 1;    // exact coordinate difference
  localparam int SQI    = 2 * DW - 1;    // one square, |d| <= 2^32
  localparam int SQW    = SQI + 1;       // sum of three squares
  localparam int LW     = 33;            // floor(sqrt) of a value below 2^66

  localparam logic [1:0] REG_STIFFNESS   = 2'd0;
  localparam logic [1:0] REG_DAMPING     = 2'd1;
  localparam logic [1:0] REG_REST_LENGTH = 2'd2;

  // Riding along with the square root.
  typedef struct packed {
    logic [2:0]          neg;   // sign of d per axis
    logic [2:0][DW-1:0]  mag;   // |d| per axis
    logic [2:0][DW-1:0]  dv;    // v1 - v2 per axis, two's complement
  } sq_side_t;

  // Riding along with the dividers.
  typedef struct packed {
    logic [2:0]          neg;
    logic [LW-1:0]       len;   // divisor, also needed afterwards
    logic [2:0][DW-1:0]  dv;
  } div_side_t;

endpackage

### design/dsf_isqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage, with side-band payload.
module dsf_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic [dsf_pkg::SQW-1:0]      in_sq,
  input  dsf_pkg::sq_side_t            in_side,
  output logic                         out_vld,
  output logic [dsf_pkg::LW-1:0]       out_root,
  output dsf_pkg::sq_side_t            out_side
);

  localparam int LW  = dsf_pkg::LW;
  localparam int SQW = dsf_pkg::SQW;
  localparam int TW  = 2 * LW + 1;

  logic              vld_r  [LW];
  logic [SQW-1:0]    rem_r  [LW];
  logic [LW-1:0]     root_r [LW];
  dsf_pkg::sq_side_t side_r [LW];

  for (genvar k = 0; k < LW; k++) begin : g_stage
    localparam int B = LW - 1 - k;
    logic              vld_in;
    logic [SQW-1:0]    rem_in;
    logic [LW-1:0]     root_in;
    dsf_pkg::sq_side_t side_in;
    logic [TW-1:0]     trial;
    logic              take;
    logic [SQW-1:0]    rem_nxt;
    logic [LW-1:0]     root_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = in_sq;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
    always_comb begin
      trial    = (TW'(root_in) << (B + 1)) | (TW'(1) << (2 * B));
      take     = TW'(rem_in) >= trial;
      rem_nxt  = take ? rem_in - trial[SQW-1:0] : rem_in;
      root_nxt = take ? (root_in | (LW'(1) << B)) : root_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
      side_r[k] <= side_in;
    end
  end

  assign out_vld  = vld_r[LW-1];
  assign out_root = root_r[LW-1];
  assign out_side = side_r[LW-1];

endmodule

### design/dsf_udiv3.sv
`timescale 1ns / 1ps
// Three-lane pipelined restoring divider, one quotient bit per stage, shared divisor.
module dsf_udiv3 #(
  parameter int FRAC_BITS = dsf_pkg::FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_vld,
  input  logic [2:0][dsf_pkg::DW+FRAC_BITS-1:0]     in_num,
  input  dsf_pkg::div_side_t                        in_side,
  output logic                                      out_vld,
  output logic [2:0][FRAC_BITS:0]                   out_quo,
  output dsf_pkg::div_side_t                        out_side
);

  localparam int NW = dsf_pkg::DW + FRAC_BITS;
  localparam int QW = FRAC_BITS + 1;   // |d| <= len, so quotient <= 2^FRAC_BITS

  logic                     vld_r  [QW];
  logic [2:0][NW-1:0]       rem_r  [QW];
  logic [2:0][QW-1:0]       quo_r  [QW];
  dsf_pkg::div_side_t       side_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic               vld_in;
    logic [2:0][NW-1:0] rem_in;
    logic [2:0][QW-1:0] quo_in;
    dsf_pkg::div_side_t side_in;
    logic [NW-1:0]      trial;
    logic [2:0][NW-1:0] rem_nxt;
    logic [2:0][QW-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = in_num;
      assign quo_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      trial = NW'(side_in.len) << B;
      for (int l = 0; l < 3; l++) begin
        if (rem_in[l] >= trial) begin
          rem_nxt[l] = rem_in[l] - trial;
          quo_nxt[l] = quo_in[l] | (QW'(1) << B);
        end else begin
          rem_nxt[l] = rem_in[l];
          quo_nxt[l] = quo_in[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      quo_r[k]  <= quo_nxt;
      side_r[k] <= side_in;
    end
  end

  assign out_vld  = vld_r[QW-1];
  assign out_quo  = quo_r[QW-1];
  assign out_side = side_r[QW-1];

endmodule

### design/damped_spring_force.sv
`timescale 1ns / 1ps
// Top level: fixed-point damped spring force between two points, fully pipelined.
//
//  channel  | handshake                    | word
//  ---------+------------------------------+-------------------------------------------
//  input    | start & !busy                | p1/p2 positions and velocities, 12 x Q15.16
//  result   | out_valid strobe, no stall   | force_one/two xyz, degenerate, saturated
//  config   | APB write psel&penable&pwrite| stiffness 0x0, damping 0x4, rest_length 0x8
//
// One word is taken every cycle; busy is tied low. A result word appears on
// out_valid after passing 4 front stages, 33 square root stages (one root bit
// each), FRAC_BITS+1 divider stages (one quotient bit each) and 9 back stages
// of multiply and saturate. Synchronous active-low reset clears the valid bits
// and the configuration registers. The receiver cannot stall, so the pipeline
// advances every cycle.
module damped_spring_force #(
  parameter int FRAC_BITS = dsf_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        start,
  output logic                        busy,
  input  logic signed [31:0]          in_p1_pos_x,
  input  logic signed [31:0]          in_p1_pos_y,
  input  logic signed [31:0]          in_p1_pos_z,
  input  logic signed [31:0]          in_p2_pos_x,
  input  logic signed [31:0]          in_p2_pos_y,
  input  logic signed [31:0]          in_p2_pos_z,
  input  logic signed [31:0]          in_p1_vel_x,
  input  logic signed [31:0]          in_p1_vel_y,
  input  logic signed [31:0]          in_p1_vel_z,
  input  logic signed [31:0]          in_p2_vel_x,
  input  logic signed [31:0]          in_p2_vel_y,
  input  logic signed [31:0]          in_p2_vel_z,
  // result channel
  output logic                        out_valid,
  output logic signed [31:0]          out_force_one_x,
  output logic signed [31:0]          out_force_one_y,
  output logic signed [31:0]          out_force_one_z,
  output logic signed [31:0]          out_force_two_x,
  output logic signed [31:0]          out_force_two_y,
  output logic signed [31:0]          out_force_two_z,
  output logic                        out_degenerate,
  output logic                        out_saturated,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dsf_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int F    = FRAC_BITS;
  localparam int WW   = dsf_pkg::WORD_W;
  localparam int DW   = dsf_pkg::DW;
  localparam int SQI  = dsf_pkg::SQI;
  localparam int SQW  = dsf_pkg::SQW;
  localparam int LW   = dsf_pkg::LW;
  localparam int NW   = DW + F;          // divider numerator |d| << F
  localparam int QW   = F + 1;           // |u|
  localparam int UW   = F + 2;           // signed u
  localparam int PW   = DW + UW;         // dv * u
  localparam int DOTW = PW + 2;          // sum of three
  localparam int SPW  = DOTW - F;        // speed
  localparam int STW  = LW + 1;          // stretch, signed and magnitude
  localparam int KPW  = WW + STW;        // stiffness * |stretch|
  localparam int KTW  = KPW - F + 1;     // signed spring term
  localparam int DPW  = WW + SPW;        // damping * |speed|
  localparam int DTW  = DPW - F + 1;     // signed damping term
  localparam int SW   = DTW + 1;         // scalar force s, signed and magnitude
  localparam int HW   = SW - WW;         // upper slice of |s|
  localparam int FPW  = SW + QW;         // full |s| * |u|
  localparam int FMW  = FPW - F;         // after the shift

  localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [31:0] NEG_MIN = 32'h8000_0000;

  // ---------------------------------------------------------------- config
  logic [31:0] stiffness_r, damping_r, rest_length_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiffness_r    <= '0;
      damping_r      <= '0;
      rest_length_r  <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        dsf_pkg::REG_STIFFNESS:   stiffness_r   <= pwdata;
        dsf_pkg::REG_DAMPING:     damping_r     <= pwdata;
        dsf_pkg::REG_REST_LENGTH: rest_length_r <= pwdata;
        default: ;  // unused slot, write dropped
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      dsf_pkg::REG_STIFFNESS:   prdata = stiffness_r;
      dsf_pkg::REG_DAMPING:     prdata = damping_r;
      dsf_pkg::REG_REST_LENGTH: prdata = rest_length_r;
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- front
  // No back-pressure anywhere: a word can enter every cycle.
  assign busy = 1'b0;

  logic signed [31:0] p1 [3], p2 [3], v1 [3], v2 [3];
  always_comb begin
    p1[0] = in_p1_pos_x; p1[1] = in_p1_pos_y; p1[2] = in_p1_pos_z;
    p2[0] = in_p2_pos_x; p2[1] = in_p2_pos_y; p2[2] = in_p2_pos_z;
    v1[0] = in_p1_vel_x; v1[1] = in_p1_vel_y; v1[2] = in_p1_vel_z;
    v2[0] = in_p2_vel_x; v2[1] = in_p2_vel_y; v2[2] = in_p2_vel_z;
  end

  // A: exact 33-bit differences
  logic                 vld_a_r;
  logic signed [DW-1:0] d_a_r [3], dv_a_r [3];
  // B: magnitude and sign of d
  logic                 vld_b_r;
  logic [DW-1:0]        mag_b_r [3];
  logic [2:0]           neg_b_r;
  logic signed [DW-1:0] dv_b_r [3];
  // C: squares
  logic                 vld_c_r;
  logic [SQI-1:0]       sq_c_r [3];
  logic [DW-1:0]        mag_c_r [3];
  logic [2:0]           neg_c_r;
  logic signed [DW-1:0] dv_c_r [3];
  // D: sum of squares
  logic                 vld_d_r;
  logic [SQW-1:0]       sum_d_r;
  dsf_pkg::sq_side_t    side_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
    end else begin
      vld_a_r <= start & ~busy;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
      vld_d_r <= vld_c_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      d_a_r[i]   <= {p1[i][31], p1[i]} - {p2[i][31], p2[i]};
      dv_a_r[i]  <= {v1[i][31], v1[i]} - {v2[i][31], v2[i]};
      // 2's complement of -2^32 reads as 2^32 unsigned, which is right
      mag_b_r[i] <= d_a_r[i][DW-1] ? DW'(-d_a_r[i]) : DW'(d_a_r[i]);
      neg_b_r[i] <= d_a_r[i][DW-1];
      dv_b_r[i]  <= dv_a_r[i];
      sq_c_r[i]  <= SQI'(mag_b_r[i] * mag_b_r[i]);
      mag_c_r[i] <= mag_b_r[i];
      neg_c_r[i] <= neg_b_r[i];
      dv_c_r[i]  <= dv_b_r[i];
      side_d_r.mag[i] <= mag_c_r[i];
      side_d_r.dv[i]  <= dv_c_r[i];
    end
    side_d_r.neg <= neg_c_r;
    sum_d_r      <= SQW'(sq_c_r[0]) + SQW'(sq_c_r[1]) + SQW'(sq_c_r[2]);
  end

  // ---------------------------------------------------------------- length
  logic              sq_vld;
  logic [LW-1:0]     sq_root;
  dsf_pkg::sq_side_t sq_side;

  dsf_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld_d_r),
    .in_sq    (sum_d_r),
    .in_side  (side_d_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // ---------------------------------------------------------------- direction
  // |u_i| = (|d_i| << F) / len, sign applied afterwards (truncation toward zero)
  logic [2:0][NW-1:0] div_num;
  dsf_pkg::div_side_t div_in_side;
  logic               div_vld;
  logic [2:0][QW-1:0] div_quo;
  dsf_pkg::div_side_t div_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      div_num[i] = NW'(sq_side.mag[i]) << F;
    end
    div_in_side.neg = sq_side.neg;
    div_in_side.len = sq_root;
    div_in_side.dv  = sq_side.dv;
  end

  dsf_udiv3 #(
    .FRAC_BITS (FRAC_BITS)
  ) u_udiv3 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (sq_vld),
    .in_num   (div_num),
    .in_side  (div_in_side),
    .out_vld  (div_vld),
    .out_quo  (div_quo),
    .out_side (div_side)
  );

  // ---------------------------------------------------------------- back end
  // E1: signed u, stretch, coincidence check
  logic                  vld_e1_r, deg_e1_r;
  logic signed [UW-1:0]  u_e1_r [3];
  logic [QW-1:0]         q_e1_r [3];
  logic [2:0]            un_e1_r;
  logic signed [DW-1:0]  dv_e1_r [3];
  logic signed [STW-1:0] stretch_e1_r;
  // E2: dv*u products, stretch magnitude
  logic                  vld_e2_r, deg_e2_r;
  logic signed [PW-1:0]  prod_e2_r [3];
  logic [STW-1:0]        st_mag_e2_r;
  logic                  st_neg_e2_r;
  logic [QW-1:0]         q_e2_r [3];
  logic [2:0]            un_e2_r;
  // E3: speed, stiffness product
  logic                  vld_e3_r, deg_e3_r;
  logic signed [SPW-1:0] speed_e3_r;
  logic [KPW-1:0]        kprod_e3_r;
  logic                  k_neg_e3_r;
  logic [QW-1:0]         q_e3_r [3];
  logic [2:0]            un_e3_r;
  // E4: speed magnitude, signed spring term
  logic                  vld_e4_r, deg_e4_r;
  logic [SPW-1:0]        sp_mag_e4_r;
  logic                  sp_neg_e4_r;
  logic signed [KTW-1:0] kterm_e4_r;
  logic [QW-1:0]         q_e4_r [3];
  logic [2:0]            un_e4_r;
  // E5: damping product
  logic                  vld_e5_r, deg_e5_r;
  logic [DPW-1:0]        dprod_e5_r;
  logic                  sp_neg_e5_r;
  logic signed [KTW-1:0] kterm_e5_r;
  logic [QW-1:0]         q_e5_r [3];
  logic [2:0]            un_e5_r;
  // E6: scalar force s
  logic                  vld_e6_r, deg_e6_r;
  logic signed [SW-1:0]  s_e6_r;
  logic [QW-1:0]         q_e6_r [3];
  logic [2:0]            un_e6_r;
  // E7: |s|
  logic                  vld_e7_r, deg_e7_r;
  logic [SW-1:0]         s_mag_e7_r;
  logic                  s_neg_e7_r;
  logic [QW-1:0]         q_e7_r [3];
  logic [2:0]            un_e7_r;
  // E8: |s|*|u| in two partial products per axis
  logic                  vld_e8_r, deg_e8_r;
  logic [WW+QW-1:0]      plo_e8_r [3];
  logic [HW+QW-1:0]      phi_e8_r [3];
  logic [2:0]            fneg_e8_r;

  // combinational helpers
  logic signed [DOTW-1:0] dot, dot_b;
  logic [DTW-1:0]         dterm;
  logic signed [SW-1:0]   dterm_s;

  always_comb begin
    dot   = DOTW'(prod_e2_r[0]) + DOTW'(prod_e2_r[1]) + DOTW'(prod_e2_r[2]);
    // round the magnitude down: bias negatives before the arithmetic shift
    dot_b = dot + (dot[DOTW-1] ? DOTW'((1 << F) - 1) : DOTW'(0));
    dterm   = {1'b0, dprod_e5_r[DPW-1:F]};
    dterm_s = sp_neg_e5_r ? -SW'(signed'(dterm)) : SW'(signed'(dterm));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_e1_r <= 1'b0;
      vld_e2_r <= 1'b0;
      vld_e3_r <= 1'b0;
      vld_e4_r <= 1'b0;
      vld_e5_r <= 1'b0;
      vld_e6_r <= 1'b0;
      vld_e7_r <= 1'b0;
      vld_e8_r <= 1'b0;
    end else begin
      vld_e1_r <= div_vld;
      vld_e2_r <= vld_e1_r;
      vld_e3_r <= vld_e2_r;
      vld_e4_r <= vld_e3_r;
      vld_e5_r <= vld_e4_r;
      vld_e6_r <= vld_e5_r;
      vld_e7_r <= vld_e6_r;
      vld_e8_r <= vld_e7_r;
    end
  end

  always_ff @(posedge clk) begin
    // E1
    for (int i = 0; i < 3; i++) begin
      u_e1_r[i]  <= div_side.neg[i] ? -signed'({1'b0, div_quo[i]})
                                    :  signed'({1'b0, div_quo[i]});
      q_e1_r[i]  <= div_quo[i];
      dv_e1_r[i] <= signed'(div_side.dv[i]);
    end
    un_e1_r      <= div_side.neg;
    deg_e1_r     <= (div_side.len == '0);
    stretch_e1_r <= signed'({1'b0, div_side.len}) - signed'(STW'(rest_length_r));

    // E2
    for (int i = 0; i < 3; i++) begin
      prod_e2_r[i] <= dv_e1_r[i] * u_e1_r[i];
      q_e2_r[i]    <= q_e1_r[i];
    end
    st_mag_e2_r <= stretch_e1_r[STW-1] ? STW'(-stretch_e1_r) : STW'(stretch_e1_r);
    st_neg_e2_r <= stretch_e1_r[STW-1];
    un_e2_r     <= un_e1_r;
    deg_e2_r    <= deg_e1_r;

    // E3
    speed_e3_r <= dot_b[DOTW-1:F];
    kprod_e3_r <= KPW'(stiffness_r) * KPW'(st_mag_e2_r);
    k_neg_e3_r <= st_neg_e2_r;
    for (int i = 0; i < 3; i++) q_e3_r[i] <= q_e2_r[i];
    un_e3_r    <= un_e2_r;
    deg_e3_r   <= deg_e2_r;

    // E4
    sp_mag_e4_r <= speed_e3_r[SPW-1] ? SPW'(-speed_e3_r) : SPW'(speed_e3_r);
    sp_neg_e4_r <= speed_e3_r[SPW-1];
    kterm_e4_r  <= k_neg_e3_r ? -signed'({1'b0, kprod_e3_r[KPW-1:F]})
                              :  signed'({1'b0, kprod_e3_r[KPW-1:F]});
    for (int i = 0; i < 3; i++) q_e4_r[i] <= q_e3_r[i];
    un_e4_r     <= un_e3_r;
    deg_e4_r    <= deg_e3_r;

    // E5
    dprod_e5_r  <= DPW'(damping_r) * DPW'(sp_mag_e4_r);
    sp_neg_e5_r <= sp_neg_e4_r;
    kterm_e5_r  <= kterm_e4_r;
    for (int i = 0; i < 3; i++) q_e5_r[i] <= q_e4_r[i];
    un_e5_r     <= un_e4_r;
    deg_e5_r    <= deg_e4_r;

    // E6: both terms stay far below 2^62, so no intermediate clamp is needed
    s_e6_r   <= SW'(kterm_e5_r) + dterm_s;
    for (int i = 0; i < 3; i++) q_e6_r[i] <= q_e5_r[i];
    un_e6_r  <= un_e5_r;
    deg_e6_r <= deg_e5_r;

    // E7
    s_mag_e7_r <= s_e6_r[SW-1] ? SW'(-s_e6_r) : SW'(s_e6_r);
    s_neg_e7_r <= s_e6_r[SW-1];
    for (int i = 0; i < 3; i++) q_e7_r[i] <= q_e6_r[i];
    un_e7_r    <= un_e6_r;
    deg_e7_r   <= deg_e6_r;

    // E8
    for (int i = 0; i < 3; i++) begin
      plo_e8_r[i]  <= (WW+QW)'(s_mag_e7_r[WW-1:0]) * (WW+QW)'(q_e7_r[i]);
      phi_e8_r[i]  <= (HW+QW)'(s_mag_e7_r[SW-1:WW]) * (HW+QW)'(q_e7_r[i]);
      fneg_e8_r[i] <= s_neg_e7_r ^ un_e7_r[i];
    end
    deg_e8_r <= deg_e7_r;
  end

  // E9: recombine, shift, saturate both signs
  logic [FMW-1:0] fmag [3];
  logic [2:0]     big_pos, big_neg;
  logic [31:0]    f2_val [3], f1_val [3];
  logic [2:0]     f2_clip, f1_clip;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fmag[i]    = FMW'(((FPW'(phi_e8_r[i]) << WW) + FPW'(plo_e8_r[i])) >> F);
      big_pos[i] = |fmag[i][FMW-1:31];
      big_neg[i] = big_pos[i] && (fmag[i] != (FMW'(1) << 31));
      if (fneg_e8_r[i]) begin
        f2_clip[i] = big_neg[i];
        f2_val[i]  = big_neg[i] ? NEG_MIN : -fmag[i][31:0];
        f1_clip[i] = big_pos[i];
        f1_val[i]  = big_pos[i] ? POS_MAX : fmag[i][31:0];
      end else begin
        f2_clip[i] = big_pos[i];
        f2_val[i]  = big_pos[i] ? POS_MAX : fmag[i][31:0];
        f1_clip[i] = big_neg[i];
        f1_val[i]  = big_neg[i] ? NEG_MIN : -fmag[i][31:0];
      end
    end
  end

  logic        out_valid_r;
  logic [31:0] f1_r [3], f2_r [3];
  logic        deg_r, sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_e8_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      f1_r[i] <= deg_e8_r ? 32'd0 : f1_val[i];
      f2_r[i] <= deg_e8_r ? 32'd0 : f2_val[i];
    end
    deg_r <= deg_e8_r;
    sat_r <= ~deg_e8_r & (|f1_clip | |f2_clip);
  end

  assign out_valid       = out_valid_r;
  assign out_force_one_x = signed'(f1_r[0]);
  assign out_force_one_y = signed'(f1_r[1]);
  assign out_force_one_z = signed'(f1_r[2]);
  assign out_force_two_x = signed'(f2_r[0]);
  assign out_force_two_y = signed'(f2_r[1]);
  assign out_force_two_z = signed'(f2_r[2]);
  assign out_degenerate  = deg_r;
  assign out_saturated   = sat_r;

endmodule

### design/dsf_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the damped spring force block, bound to the top level.
module dsf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               busy,
  input logic               out_valid,
  input logic signed [31:0] out_force_one_x,
  input logic signed [31:0] out_force_one_y,
  input logic signed [31:0] out_force_one_z,
  input logic signed [31:0] out_force_two_x,
  input logic signed [31:0] out_force_two_y,
  input logic signed [31:0] out_force_two_z,
  input logic               out_degenerate,
  input logic               out_saturated
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_force_one_x == 0 && out_force_one_y == 0 && out_force_one_z == 0 &&
      out_force_two_x == 0 && out_force_two_y == 0 && out_force_two_z == 0 &&
      !out_saturated)
    else $error("coincident points gave nonzero force");

  a_opposite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_saturated |->
      out_force_one_x + out_force_two_x == 32'sd0 &&
      out_force_one_y + out_force_two_y == 32'sd0 &&
      out_force_one_z + out_force_two_z == 32'sd0)
    else $error("forces not opposite without clipping");

  a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_force_one_x == 32'sh7fffffff || out_force_one_x == 32'sh80000000 ||
      out_force_one_y == 32'sh7fffffff || out_force_one_y == 32'sh80000000 ||
      out_force_one_z == 32'sh7fffffff || out_force_one_z == 32'sh80000000 ||
      out_force_two_x == 32'sh7fffffff || out_force_two_x == 32'sh80000000 ||
      out_force_two_y == 32'sh7fffffff || out_force_two_y == 32'sh80000000 ||
      out_force_two_z == 32'sh7fffffff || out_force_two_z == 32'sh80000000)
    else $error("saturated flag without a component at a rail");

endmodule

bind damped_spring_force dsf_checker u_dsf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_force_one_x (out_force_one_x),
  .out_force_one_y (out_force_one_y),
  .out_force_one_z (out_force_one_z),
  .out_force_two_x (out_force_two_x),
  .out_force_two_y (out_force_two_y),
  .out_force_two_z (out_force_two_z),
  .out_degenerate  (out_degenerate),
  .out_saturated   (out_saturated)
);

### dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for damped_spring_force: directed and random words checked against a local predictor.
module tb_top;

  localparam int FRAC   = 16;
  localparam int LAT    = 47 + FRAC;  // start to out_valid
  localparam int WD_MAX = 4000;       // cycles with nothing accepted and no result

  typedef struct packed {
    logic signed [31:0] p1x, p1y, p1z, p2x, p2y, p2z;
    logic signed [31:0] v1x, v1y, v1z, v2x, v2y, v2z;
  } spring_word_t;

  typedef struct packed {
    logic signed [31:0] f1x, f1y, f1z, f2x, f2y, f2z;
    logic degen, sat;
  } force_word_t;

  logic clk = 1'b0, rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  spring_word_t drv = '0;
  logic out_valid, out_degenerate, out_saturated;
  logic signed [31:0] out_force_one_x, out_force_one_y, out_force_one_z;
  logic signed [31:0] out_force_two_x, out_force_two_y, out_force_two_z;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [dsf_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  damped_spring_force #(.FRAC_BITS(FRAC)) dut (
    .clk, .rst_n, .start, .busy,
    .in_p1_pos_x(drv.p1x), .in_p1_pos_y(drv.p1y), .in_p1_pos_z(drv.p1z),
    .in_p2_pos_x(drv.p2x), .in_p2_pos_y(drv.p2y), .in_p2_pos_z(drv.p2z),
    .in_p1_vel_x(drv.v1x), .in_p1_vel_y(drv.v1y), .in_p1_vel_z(drv.v1z),
    .in_p2_vel_x(drv.v2x), .in_p2_vel_y(drv.v2y), .in_p2_vel_z(drv.v2z),
    .out_valid, .out_force_one_x, .out_force_one_y, .out_force_one_z,
    .out_force_two_x, .out_force_two_y, .out_force_two_z,
    .out_degenerate, .out_saturated,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Predictor copy of the registers.
  logic [31:0] k_stiff, k_damp, k_rest;

  spring_word_t pending_words[$];
  force_word_t  expected_forces[$];
  int  gap_pct = 24;
  bit  failed = 1'b0;
  int  idle_cycles = 0;

  localparam logic signed [127:0] CLAMP = (128'sd1 <<< 62) - 1;

  // (a*b) >> FRAC with magnitude truncation, clamped to +-(2^62-1)
  function automatic logic signed [127:0] fx_mul(logic signed [127:0] a,
                                                 logic signed [127:0] b);
    logic signed [127:0] ma, mb, r;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    r = (ma * mb) >>> FRAC;
    if (r > CLAMP) r = CLAMP;
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic logic signed [31:0] clip32(logic signed [127:0] x, ref bit c);
    if (x > 128'sh7FFFFFFF) begin
      c = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (x < -128'sh80000000) begin
      c = 1'b1;
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  function automatic force_word_t spring_force(spring_word_t w);
    logic signed [127:0] d[3], dv[3], u[3];
    logic signed [127:0] dot, speed, s, f;
    logic [127:0] sum, len, cand;
    logic signed [31:0] o1[3], o2[3];
    force_word_t r;
    bit c;
    d[0] = w.p1x - w.p2x; d[1] = w.p1y - w.p2y; d[2] = w.p1z - w.p2z;
    dv[0] = w.v1x - w.v2x; dv[1] = w.v1y - w.v2y; dv[2] = w.v1z - w.v2z;
    c = 1'b0;
    sum = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
    len = 0;
    for (int b = 34; b >= 0; b--) begin
      cand = len | (128'd1 << b);
      if (cand * cand <= sum) len = cand;
    end
    r = '0;
    if (len == 0) begin
      r.degen = 1'b1;
      return r;
    end
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      u[i] = (d[i] <<< FRAC) / $signed(len);  // truncates toward zero
      dot += dv[i] * u[i];
    end
    speed = (dot < 0) ? -((-dot) >>> FRAC) : (dot >>> FRAC);
    s = fx_mul($signed({96'd0, k_stiff}), $signed(len) - $signed({96'd0, k_rest}))
      + fx_mul($signed({96'd0, k_damp}), speed);
    for (int i = 0; i < 3; i++) begin
      f = fx_mul(s, u[i]);
      o2[i] = clip32(f, c);
      o1[i] = clip32(-f, c);
    end
    r.f1x = o1[0]; r.f1y = o1[1]; r.f1z = o1[2];
    r.f2x = o2[0]; r.f2y = o2[1]; r.f2z = o2[2];
    r.sat = c;
    return r;
  endfunction

  // Driver: one word per accept, random idle per gap_pct.
  always @(negedge clk) begin
    if (rst_n && pending_words.size() > 0 && !(start && busy)
        && $urandom_range(99) >= gap_pct) begin
      // the word driven last edge was taken unless busy held it
      drv <= pending_words[0];
      start <= 1'b1;
    end else if (!(start && busy)) begin
      start <= 1'b0;
    end
  end

  // Accept and monitor at the rising edge.
  always @(posedge clk) begin
    force_word_t e, a;
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (start && !busy) begin
        expected_forces.push_back(spring_force(drv));
        void'(pending_words.pop_front());
      end
      if (out_valid) begin
        a = {out_force_one_x, out_force_one_y, out_force_one_z,
             out_force_two_x, out_force_two_y, out_force_two_z,
             out_degenerate, out_saturated};
        if (expected_forces.size() == 0) begin
          $error("result word with nothing expected");
          failed = 1'b1;
        end else begin
          e = expected_forces.pop_front();
          if (a.f1x !== e.f1x) begin
            $error("force_one_x exp %0d got %0d", e.f1x, a.f1x); failed = 1'b1;
          end
          if (a.f1y !== e.f1y) begin
            $error("force_one_y exp %0d got %0d", e.f1y, a.f1y); failed = 1'b1;
          end
          if (a.f1z !== e.f1z) begin
            $error("force_one_z exp %0d got %0d", e.f1z, a.f1z); failed = 1'b1;
          end
          if (a.f2x !== e.f2x) begin
            $error("force_two_x exp %0d got %0d", e.f2x, a.f2x); failed = 1'b1;
          end
          if (a.f2y !== e.f2y) begin
            $error("force_two_y exp %0d got %0d", e.f2y, a.f2y); failed = 1'b1;
          end
          if (a.f2z !== e.f2z) begin
            $error("force_two_z exp %0d got %0d", e.f2z, a.f2z); failed = 1'b1;
          end
          if (a.degen !== e.degen) begin
            $error("degenerate exp %0b got %0b", e.degen, a.degen); failed = 1'b1;
          end
          if (a.sat !== e.sat) begin
            $error("saturated exp %0b got %0b", e.sat, a.sat); failed = 1'b1;
          end
        end
      end
    end
  end

  // Watchdog: no accept and no result for too long.
  always @(posedge clk) begin
    if (idle_cycles >= WD_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      dsf_pkg::REG_STIFFNESS:   k_stiff = val;
      dsf_pkg::REG_DAMPING:     k_damp  = val;
      dsf_pkg::REG_REST_LENGTH: k_rest  = val;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_spring(logic [31:0] ks, logic [31:0] kd, logic [31:0] rl);
    reg_write(dsf_pkg::REG_STIFFNESS, ks);
    reg_write(dsf_pkg::REG_DAMPING, kd);
    reg_write(dsf_pkg::REG_REST_LENGTH, rl);
  endtask

  // Every word yields a result, so draining expectations plus the latency is idle.
  task automatic drain();
    while (pending_words.size() > 0 || expected_forces.size() > 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(2000000)) - 1000000;  // near the origin
      2: return $signed($urandom_range(131072)) - 65536;     // within one unit
      default: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
    endcase
  endfunction

  function automatic spring_word_t rnd_word();
    spring_word_t w;
    int m;
    m = $urandom_range(9) < 2 ? 0 : ($urandom_range(9) < 1 ? 3 : 1 + $urandom_range(1));
    w.p1x = rnd_coord(m); w.p1y = rnd_coord(m); w.p1z = rnd_coord(m);
    w.p2x = rnd_coord(m); w.p2y = rnd_coord(m); w.p2z = rnd_coord(m);
    w.v1x = rnd_coord(m); w.v1y = rnd_coord(m); w.v1z = rnd_coord(m);
    w.v2x = rnd_coord(m); w.v2y = rnd_coord(m); w.v2z = rnd_coord(m);
    // occasionally coincident points
    if ($urandom_range(29) == 0) begin
      w.p2x = w.p1x; w.p2y = w.p1y; w.p2z = w.p1z;
    end
    return w;
  endfunction

  function automatic logic [31:0] rnd_const();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(32'h0004_0000);
      2: return $urandom_range(32'h0000_1000);
      default: return $urandom_range(1) ? 32'hFFFFFFFF : 32'h0;
    endcase
  endfunction

  initial begin
    spring_word_t w;
    k_stiff = 0; k_damp = 0; k_rest = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: unit constants first, then the extremes.
    set_spring(32'h0001_0000, 32'h0000_8000, 32'h0001_0000);
    w = '0;
    pending_words.push_back(w);                         // coincident at origin
    w.p1x = 32'h0002_0000; pending_words.push_back(w);  // stretched along x
    w.v1x = 32'h0001_0000; pending_words.push_back(w);  // moving apart
    w = '0; w.p1y = 32'h0000_8000; w.v2y = 32'h0003_0000;
    pending_words.push_back(w);                         // compressed along y
    w = '0; w.p1z = -32'sh0001_0000; pending_words.push_back(w);
    w = '0; w.p1x = 32'h0000_0001; pending_words.push_back(w);  // smallest length
    w = '1; w.p2x = '1; pending_words.push_back(w);     // coincident, all ones
    drain();
    set_spring(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0);
    w = '0;
    w.p1x = 32'h7FFFFFFF; w.p2x = 32'h80000000;         // longest span per axis
    w.p1y = 32'h7FFFFFFF; w.p2y = 32'h80000000;
    w.p1z = 32'h7FFFFFFF; w.p2z = 32'h80000000;
    w.v1x = 32'h80000000; w.v2x = 32'h7FFFFFFF;
    pending_words.push_back(w);
    w.p1x = 32'h80000000; w.p2x = 32'h7FFFFFFF; pending_words.push_back(w);
    w = '0; w.p1x = 32'h0000_0100; pending_words.push_back(w);  // short span along x, below the rails
    w = '0; w.p2y = 32'h0000_0001; w.v1y = 32'h7FFFFFFF; pending_words.push_back(w);
    drain();
    set_spring(32'h0, 32'h0, 32'hFFFFFFFF);
    w = '0; w.p1x = 32'h0001_0000; pending_words.push_back(w);  // zero force
    drain();
    set_spring(32'h0000_0001, 32'h0, 32'hFFFFFFFF);
    w = '0; w.p1x = 32'h7FFFFFFF; w.p2x = 32'h80000000; pending_words.push_back(w);
    drain();

    // Random: three idle profiles, several constant sets each.
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 24 : ((ph == 1) ? 85 : 0);
      for (int cs = 0; cs < 5; cs++) begin
        set_spring(rnd_const(), rnd_const(), rnd_const());
        for (int n = 0; n < 70; n++) pending_words.push_back(rnd_word());
        drain();
      end
    end

    if (!failed && expected_forces.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
